// ===== rtl/core/rau_pkg.sv =====
`default_nettype none

package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int NUM_W         = 33;
  localparam int DEN_W         = 31;
  localparam int TYPE_W        = 3;

  localparam logic [TYPE_W-1:0] OP_ADD   = 3'd0;
  localparam logic [TYPE_W-1:0] OP_SUB   = 3'd1;
  localparam logic [TYPE_W-1:0] OP_MUL   = 3'd2;
  localparam logic [TYPE_W-1:0] OP_DIV   = 3'd3;
  localparam logic [TYPE_W-1:0] OP_CMP   = 3'd4;
  localparam logic [TYPE_W-1:0] OP_RECIP = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rau_mul.sv =====
`default_nettype none

module rau_mul #(
  parameter int W = rau_pkg::OPERAND_WIDTH
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rau_gcd.sv =====
`default_nettype none

module rau_gcd #(
  parameter int MW = 2 * rau_pkg::OPERAND_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MW-1:0]       a_in,
  input  logic [MW-1:0]       b_in,
  output rau_pkg::unit_stat_t stat,
  output logic [MW-1:0]       g
);

  localparam int KW = $clog2(MW);

  typedef enum logic [0:0] {
    G_IDLE,
    G_RUN
  } gstate_t;

  gstate_t       state;
  logic [MW-1:0] a;
  logic [MW-1:0] b;
  logic [KW-1:0] k;
  logic [MW:0]   diff_ab;
  logic [MW:0]   diff_ba;

  assign diff_ab = {1'b0, a} - {1'b0, b};
  assign diff_ba = {1'b0, b} - {1'b0, a};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      stat  <= '0;
    end else begin
      stat.done <= (state == G_RUN) && (a == '0);
      case (state)
        G_IDLE: begin
          if (start) begin
            a         <= a_in;
            b         <= b_in;
            k         <= '0;
            stat.busy <= 1'b1;
            state     <= G_RUN;
          end
        end
        G_RUN: begin
          if (a == '0) begin
            g         <= b << k;
            stat.busy <= 1'b0;
            state     <= G_IDLE;
          end else if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + 1'b1;
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (!diff_ab[MW]) begin
            a <= diff_ab[MW:1];
          end else begin
            b <= diff_ba[MW:1];
          end
        end
        default: begin
          state <= G_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rau_div.sv =====
`default_nettype none

module rau_div #(
  parameter int MW = 2 * rau_pkg::OPERAND_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MW-1:0]       dividend,
  input  logic [MW-1:0]       divisor,
  output rau_pkg::unit_stat_t stat,
  output logic [MW-1:0]       quo
);

  localparam int CW = $clog2(MW);

  typedef enum logic [0:0] {
    D_IDLE,
    D_RUN
  } dstate_t;

  dstate_t       state;
  logic [MW-1:0] rem;
  logic [MW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic [MW:0]   rsh;
  logic [MW+1:0] trial;

  assign rsh   = {rem, quo[MW-1]};
  assign trial = {1'b0, rsh} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      stat  <= '0;
    end else begin
      stat.done <= (state == D_RUN) && (cnt == '0);
      case (state)
        D_IDLE: begin
          if (start) begin
            quo       <= dividend;
            dsr       <= divisor;
            rem       <= '0;
            cnt       <= CW'(MW - 1);
            stat.busy <= 1'b1;
            state     <= D_RUN;
          end
        end
        D_RUN: begin
          if (!trial[MW+1]) begin
            rem <= trial[MW-1:0];
            quo <= {quo[MW-2:0], 1'b1};
          end else begin
            rem <= rsh[MW-1:0];
            quo <= {quo[MW-2:0], 1'b0};
          end
          if (cnt == '0) begin
            stat.busy <= 1'b0;
            state     <= D_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: takes a request of two signed fractions and an
// operation (add, subtract, multiply, divide, compare only, reciprocal of the
// left operand) and returns the result reduced by its gcd, with the sign in
// res_num and res_den positive, plus a three-way compare of left against
// right. A zero denominator, divide by zero or reciprocal of zero sets status
// and returns the reduced left operand (lhs_num over 0 if lhs_den is zero).
// One request at a time: req_stall is high from acceptance until the result
// moves into the output register, which may still wait on res_stall while
// the next request is taken. Each request runs the binary gcd steps (at most
// about 4*OPERAND_WIDTH) and then 4*OPERAND_WIDTH restoring-division steps,
// all on the shared gcd and divider units; a zero result, or an error with
// lhs_den zero, skips the gcd and the divisions.
`default_nettype none

module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [rau_pkg::TYPE_W-1:0]           req_type,
  input  logic signed [OPERAND_WIDTH-1:0]      lhs_num,
  input  logic signed [OPERAND_WIDTH-1:0]      lhs_den,
  input  logic signed [OPERAND_WIDTH-1:0]      rhs_num,
  input  logic signed [OPERAND_WIDTH-1:0]      rhs_den,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic signed [rau_pkg::NUM_W-1:0]     res_num,
  output logic [rau_pkg::DEN_W-1:0]            res_den,
  output logic signed [1:0]                    cmp_sign,
  output logic                                 status
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int SW = MW + 1;
  localparam int NW = (SW > rau_pkg::NUM_W) ? SW : rau_pkg::NUM_W;
  localparam int DW = (MW > rau_pkg::DEN_W) ? MW : rau_pkg::DEN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FORM,
    S_GCD,
    S_DIV_N,
    S_DIV_D,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [rau_pkg::TYPE_W-1:0]      op;
  logic signed [W-1:0]             ln;
  logic signed [W-1:0]             ld;
  logic signed [W-1:0]             rn;
  logic signed [W-1:0]             rd;
  logic [2:0]                      mstep;
  logic signed [MW-1:0]            p0;
  logic signed [MW-1:0]            p1;
  logic signed [MW-1:0]            p2;
  logic signed [MW-1:0]            p3;
  logic [MW-1:0]                   mag_n;
  logic [MW-1:0]                   mag_d;
  logic                            neg;
  logic [MW-1:0]                   q_num;
  logic signed [rau_pkg::NUM_W-1:0] pend_num;
  logic [rau_pkg::DEN_W-1:0]       pend_den;
  logic signed [1:0]               pend_cmp;
  logic                            pend_err;

  logic signed [W-1:0]             mul_a;
  logic signed [W-1:0]             mul_b;
  logic signed [MW-1:0]            prod;

  logic signed [SW-1:0]            f_sum;
  logic signed [SW-1:0]            f_diff;
  logic signed [SW-1:0]            f_n;
  logic signed [SW-1:0]            f_d;
  logic                            f_zden;
  logic                            f_err;
  logic signed [1:0]               f_cmp;
  logic [MW-1:0]                   f_mag_n;
  logic [MW-1:0]                   f_mag_d;
  logic                            f_reduce;

  rau_pkg::unit_stat_t             gcd_stat;
  rau_pkg::unit_stat_t             div_stat;
  logic                            gcd_start;
  logic                            div_start;
  logic [MW-1:0]                   gcd_g;
  logic [MW-1:0]                   div_dividend;
  logic [MW-1:0]                   div_quo;

  logic signed [SW-1:0]            snum;
  logic signed [NW-1:0]            num_ext;
  logic [DW-1:0]                   den_ext;
  logic signed [NW-1:0]            ln_ext;

  always_comb begin
    case (mstep)
      3'd0: begin
        mul_a = ln;
        mul_b = rd;
      end
      3'd1: begin
        mul_a = ld;
        mul_b = rn;
      end
      3'd2: begin
        mul_a = ln;
        mul_b = rn;
      end
      default: begin
        mul_a = ld;
        mul_b = rd;
      end
    endcase
  end

  rau_mul #(.W(W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    f_sum  = SW'(p0) + SW'(p1);
    f_diff = SW'(p0) - SW'(p1);
    f_zden = (ld == '0) || (rd == '0);
    if (f_zden || f_diff == '0) begin
      f_cmp = 2'sb00;
    end else if (f_diff[SW-1] ^ p3[MW-1]) begin
      f_cmp = 2'sb11;
    end else begin
      f_cmp = 2'sb01;
    end
    case (op)
      rau_pkg::OP_ADD: begin
        f_n = f_sum;
        f_d = SW'(p3);
      end
      rau_pkg::OP_SUB: begin
        f_n = f_diff;
        f_d = SW'(p3);
      end
      rau_pkg::OP_MUL: begin
        f_n = SW'(p2);
        f_d = SW'(p3);
      end
      rau_pkg::OP_DIV: begin
        f_n = SW'(p0);
        f_d = SW'(p1);
      end
      rau_pkg::OP_RECIP: begin
        f_n = SW'(ld);
        f_d = SW'(ln);
      end
      default: begin
        f_n = SW'(ln);
        f_d = SW'(ld);
      end
    endcase
    f_err = f_zden
         || (op == rau_pkg::OP_DIV && rn == '0)
         || (op == rau_pkg::OP_RECIP && ln == '0);
    if (f_err) begin
      f_n = SW'(ln);
      f_d = SW'(ld);
    end
    f_mag_n  = f_n[SW-1] ? MW'(-f_n) : MW'(f_n);
    f_mag_d  = f_d[SW-1] ? MW'(-f_d) : MW'(f_d);
    f_reduce = !(f_err && ld == '0) && (f_n != '0);
  end

  assign gcd_start    = (state == S_FORM) && f_reduce;
  assign div_start    = ((state == S_GCD) && gcd_stat.done)
                     || ((state == S_DIV_N) && div_stat.done);
  assign div_dividend = (state == S_GCD) ? mag_n : mag_d;

  rau_gcd #(.MW(MW)) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a_in  (f_mag_n),
    .b_in  (f_mag_d),
    .stat  (gcd_stat),
    .g     (gcd_g)
  );

  rau_div #(.MW(MW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_g),
    .stat     (div_stat),
    .quo      (div_quo)
  );

  assign snum    = neg ? -signed'({1'b0, q_num}) : signed'({1'b0, q_num});
  assign num_ext = NW'(snum);
  assign den_ext = DW'(div_quo);
  assign ln_ext  = NW'(ln);

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= req_type;
            ln    <= lhs_num;
            ld    <= lhs_den;
            rn    <= rhs_num;
            rd    <= rhs_den;
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          case (mstep)
            3'd1:    p0 <= prod;
            3'd2:    p1 <= prod;
            3'd3:    p2 <= prod;
            3'd4:    p3 <= prod;
            default: p0 <= p0;
          endcase
          if (mstep == 3'd4) begin
            state <= S_FORM;
          end else begin
            mstep <= mstep + 1'b1;
          end
        end
        S_FORM: begin
          pend_cmp <= f_cmp;
          pend_err <= f_err;
          mag_n    <= f_mag_n;
          mag_d    <= f_mag_d;
          neg      <= f_n[SW-1] ^ f_d[SW-1];
          if (f_reduce) begin
            state <= S_GCD;
          end else if (f_err && ld == '0) begin
            pend_num <= ln_ext[rau_pkg::NUM_W-1:0];
            pend_den <= '0;
            state    <= S_FINISH;
          end else begin
            pend_num <= '0;
            pend_den <= rau_pkg::DEN_W'(1);
            state    <= S_FINISH;
          end
        end
        S_GCD: begin
          if (gcd_stat.done) begin
            state <= S_DIV_N;
          end
        end
        S_DIV_N: begin
          if (div_stat.done) begin
            q_num <= div_quo;
            state <= S_DIV_D;
          end
        end
        S_DIV_D: begin
          if (div_stat.done) begin
            pend_num <= num_ext[rau_pkg::NUM_W-1:0];
            pend_den <= den_ext[rau_pkg::DEN_W-1:0];
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res_num   <= pend_num;
            res_den   <= pend_den;
            cmp_sign  <= pend_cmp;
            status    <= pend_err;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted but block not busy next cycle");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    gcd_stat.done |-> gcd_g != '0)
    else $error("gcd unit returned zero");

  a_cmp_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> cmp_sign != 2'sb10)
    else $error("invalid compare code");

  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) && res_valid && res_stall |=> state == S_FINISH)
    else $error("result overwrote a stalled output");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (gcd_start |-> !gcd_stat.busy) and (div_start |-> !div_stat.busy))
    else $error("shared unit started while busy");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit;

  localparam int OW = rau_pkg::OPERAND_WIDTH;
  localparam int TW = rau_pkg::TYPE_W;
  localparam int NUMW = rau_pkg::NUM_W;
  localparam int DENW = rau_pkg::DEN_W;
  localparam logic signed [OW-1:0] OPND_MIN = {1'b1, {(OW-1){1'b0}}};
  localparam logic signed [OW-1:0] OPND_MAX = ~OPND_MIN;
  localparam logic [TW-1:0] OP_SPARE_A = 3'd6;
  localparam logic [TW-1:0] OP_SPARE_B = 3'd7;
  localparam int RANDOM_REQUESTS = 1450;
  localparam int LONG_HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic signed [NUMW-1:0] num;
    logic [DENW-1:0]        den;
    logic signed [1:0]      cmp;
    logic                   status;
  } rational_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [TW-1:0] req_type = rau_pkg::OP_ADD;
  logic signed [OW-1:0] lhs_num = '0;
  logic signed [OW-1:0] lhs_den = '0;
  logic signed [OW-1:0] rhs_num = '0;
  logic signed [OW-1:0] rhs_den = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [NUMW-1:0] res_num;
  logic [DENW-1:0] res_den;
  logic signed [1:0] cmp_sign;
  logic status;

  rational_result_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit sender_gaps = 1'b0;
  int burst_left = 0;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int pattern_left = 0;

  rational_arithmetic_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .lhs_num   (lhs_num),
    .lhs_den   (lhs_den),
    .rhs_num   (rhs_num),
    .rhs_den   (rhs_den),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_num   (res_num),
    .res_den   (res_den),
    .cmp_sign  (cmp_sign),
    .status    (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int sgn(input longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic void reduce_fraction(input longint n, input longint d,
                                          output longint rn, output longint rd);
    longint unsigned a;
    longint unsigned b;
    longint unsigned t;
    if (n == 0) begin
      rn = 0;
      rd = 1;
      return;
    end
    a = (n < 0) ? -n : n;
    b = (d < 0) ? -d : d;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    n = n / longint'(a);
    d = d / longint'(a);
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    rn = n;
    rd = d;
  endfunction

  function automatic rational_result_t compute_rational(
      input logic [TW-1:0] op, input logic signed [OW-1:0] ln_i,
      input logic signed [OW-1:0] ld_i, input logic signed [OW-1:0] rn_i,
      input logic signed [OW-1:0] rd_i);
    rational_result_t r;
    longint ln;
    longint ld;
    longint rn;
    longint rd;
    longint n;
    longint d;
    longint on;
    longint od;
    int cmp;
    bit err;
    ln = ln_i;
    ld = ld_i;
    rn = rn_i;
    rd = rd_i;
    n = 0;
    d = 1;
    cmp = 0;
    err = 1'b0;
    if (ld == 0 || rd == 0) begin
      err = 1'b1;
    end else begin
      cmp = sgn(ln * rd - ld * rn) * sgn(ld) * sgn(rd);
      case (op)
        rau_pkg::OP_ADD: begin
          n = ln * rd + ld * rn;
          d = ld * rd;
        end
        rau_pkg::OP_SUB: begin
          n = ln * rd - ld * rn;
          d = ld * rd;
        end
        rau_pkg::OP_MUL: begin
          n = ln * rn;
          d = ld * rd;
        end
        rau_pkg::OP_DIV: begin
          err = (rn == 0);
          n = ln * rd;
          d = rn * ld;
        end
        rau_pkg::OP_RECIP: begin
          err = (ln == 0);
          n = ld;
          d = ln;
        end
        default: begin
          n = ln;
          d = ld;
        end
      endcase
    end
    if (err && ld == 0) begin
      on = ln;
      od = 0;
    end else if (err) begin
      reduce_fraction(ln, ld, on, od);
    end else begin
      reduce_fraction(n, d, on, od);
    end
    r.num = on[NUMW-1:0];
    r.den = od[DENW-1:0];
    r.cmp = cmp[1:0];
    r.status = err;
    return r;
  endfunction

  // predict on every accepted request
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall)
      pending_results.push_back(compute_rational(req_type, lhs_num, lhs_den,
                                                 rhs_num, rhs_den));
  end

  always @(posedge clk) begin
    rational_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: res_num %0d res_den %0d", res_num,
               res_den);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (res_num !== want.num) begin
          $error("res_num expected %0d actual %0d", want.num, res_num);
          mismatches++;
        end
        if (res_den !== want.den) begin
          $error("res_den expected %0d actual %0d", want.den, res_den);
          mismatches++;
        end
        if (cmp_sign !== want.cmp) begin
          $error("cmp_sign expected %0d actual %0d", want.cmp, cmp_sign);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: long hold on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      if (pattern_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(20, 400);
      end
      pattern_left--;
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 3) != 0);
        default: res_stall <= ~res_stall;
      endcase
    end
  end

  task automatic send_request(input logic [TW-1:0] op,
                              input logic signed [OW-1:0] ln,
                              input logic signed [OW-1:0] ld,
                              input logic signed [OW-1:0] rn,
                              input logic signed [OW-1:0] rd);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      @(negedge clk) req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left != 0)
      burst_left--;
    @(negedge clk);
    req_type <= op;
    lhs_num <= ln;
    lhs_den <= ld;
    rhs_num <= rn;
    rhs_den <= rd;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  function automatic logic signed [OW-1:0] random_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return OW'($urandom);
      5, 6, 7: return OW'(int'($urandom_range(0, 32)) - 16);
      8: begin
        case ($urandom_range(0, 4))
          0: return OPND_MIN;
          1: return OPND_MAX;
          2: return OW'(-1);
          3: return OW'(1);
          default: return '0;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) != 0)
          return OW'(-(1 << $urandom_range(0, OW - 2)));
        return OW'(1 << $urandom_range(0, OW - 2));
      end
    endcase
  endfunction

  task automatic send_random_request();
    int r;
    logic [TW-1:0] op;
    logic signed [OW-1:0] ln;
    logic signed [OW-1:0] ld;
    logic signed [OW-1:0] rn;
    logic signed [OW-1:0] rd;
    r = $urandom_range(0, 13);
    op = (r < 12) ? TW'(r % 6) : ((r == 12) ? OP_SPARE_A : OP_SPARE_B);
    ln = random_operand();
    ld = random_operand();
    rn = random_operand();
    rd = random_operand();
    if (ld == 0 && $urandom_range(0, 7) != 0)
      ld = OW'(1);
    if (rd == 0 && $urandom_range(0, 7) != 0)
      rd = OW'(1);
    if ($urandom_range(0, 39) == 0) begin
      case ($urandom_range(0, 3))
        0: ln = '0;
        1: ld = '0;
        2: rn = '0;
        default: rd = '0;
      endcase
    end
    send_request(op, ln, ld, rn, rd);
  endtask

  task automatic test_each_operation();
    sender_gaps = 1'b0;
    send_request(rau_pkg::OP_ADD, 1, 2, 1, 3);
    send_request(rau_pkg::OP_SUB, 1, 2, 1, 3);
    send_request(rau_pkg::OP_MUL, 2, 3, 3, 4);
    send_request(rau_pkg::OP_DIV, 2, 3, 4, 5);
    send_request(rau_pkg::OP_CMP, 6, 8, 3, 4);
    send_request(rau_pkg::OP_RECIP, -3, 4, 7, 9);
    send_request(OP_SPARE_A, 10, -4, 1, 2);
    send_request(OP_SPARE_B, -9, 12, 5, -3);
  endtask

  task automatic test_operand_extremes();
    send_request(rau_pkg::OP_ADD, OPND_MIN, OPND_MAX, OPND_MIN, OPND_MAX);
    send_request(rau_pkg::OP_MUL, OPND_MIN, OPND_MIN, OPND_MIN, 1);
    send_request(rau_pkg::OP_SUB, OPND_MAX, OPND_MIN, OPND_MIN, OPND_MAX);
    send_request(rau_pkg::OP_DIV, OPND_MIN, 1, 1, OPND_MIN);
    send_request(rau_pkg::OP_RECIP, OPND_MIN, OPND_MAX, 0, 1);
    send_request(rau_pkg::OP_CMP, OPND_MAX, 1, OPND_MIN, 1);
  endtask

  task automatic test_special_cases();
    send_request(rau_pkg::OP_ADD, 1, 2, -1, 2);
    send_request(rau_pkg::OP_MUL, 0, 5, 7, 3);
    send_request(rau_pkg::OP_ADD, 5, 0, 1, 2);
    send_request(rau_pkg::OP_SUB, 3, 4, 1, 0);
    send_request(rau_pkg::OP_CMP, -7, 0, 2, 0);
    send_request(rau_pkg::OP_DIV, 3, 6, 0, 5);
    send_request(rau_pkg::OP_RECIP, 0, -7, 2, 3);
    send_request(rau_pkg::OP_CMP, 1, -2, 1, -2);
    send_request(rau_pkg::OP_CMP, 3, -4, -5, -7);
    send_request(rau_pkg::OP_RECIP, 4, 0, 1, 1);
  endtask

  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    long_hold_req = 1'b1;
    repeat (24) send_random_request();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0) begin
        sender_gaps = ($urandom_range(0, 2) != 0);
        burst_left = 0;
      end
      send_random_request();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_each_operation();
    test_operand_extremes();
    test_special_cases();
    test_output_backpressure();
    test_random_traffic();
    @(negedge clk) req_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
